// ===== design/fdx_pkg.sv =====
// Shared types and constants for the frame deframer with XOR checksum.
`timescale 1ns / 1ps

package fdx_pkg;

  localparam logic [7:0] START_BYTE_RESET = 8'hFE;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        frame_ok;
    logic [15:0] function_code;
    logic [15:0] payload_length;
  } fdx_result_t;

endpackage

// ===== design/fdx_fsm.sv =====
// Frame phase sequencer, checksum accumulator and result register.
`timescale 1ns / 1ps

module fdx_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  logic [7:0]          item_byte_i,
  input  logic [7:0]          start_byte_i,
  input  logic                out_stall_i,
  output logic                item_take_o,
  output logic                out_valid_o,
  output fdx_pkg::fdx_result_t result_o
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_FMSB = 3'd1,
    PH_FLSB = 3'd2,
    PH_LMSB = 3'd3,
    PH_LLSB = 3'd4,
    PH_PAY  = 3'd5,
    PH_CHK  = 3'd6
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [15:0]          function_q, function_d;
  logic [15:0]          length_q, length_d;
  logic [15:0]          index_q, index_d;
  logic [7:0]           xor_q, xor_d;
  logic                 out_valid_q;
  fdx_pkg::fdx_result_t result_q, result_d;
  logic                 out_free;
  logic [15:0]          index_inc;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign item_take_o = item_valid_i && out_free;
  assign index_inc   = index_q + 16'd1;

  always_comb begin
    phase_d    = phase_q;
    function_d = function_q;
    length_d   = length_q;
    index_d    = index_q;
    xor_d      = xor_q;
    result_d   = '0;
    unique case (phase_q)
      PH_WAIT: begin
        if (item_byte_i == start_byte_i) begin
          function_d = '0;
          length_d   = '0;
          index_d    = '0;
          xor_d      = item_byte_i;
          phase_d    = PH_FMSB;
        end
      end
      PH_FMSB: begin
        function_d = {item_byte_i, 8'h00};
        xor_d      = xor_q ^ item_byte_i;
        phase_d    = PH_FLSB;
      end
      PH_FLSB: begin
        function_d = {function_q[15:8], item_byte_i};
        xor_d      = xor_q ^ item_byte_i;
        phase_d    = PH_LMSB;
      end
      PH_LMSB: begin
        length_d = {item_byte_i, 8'h00};
        xor_d    = xor_q ^ item_byte_i;
        phase_d  = PH_LLSB;
      end
      PH_LLSB: begin
        length_d = {length_q[15:8], item_byte_i};
        xor_d    = xor_q ^ item_byte_i;
        phase_d  = ({length_q[15:8], item_byte_i} != 16'd0) ? PH_PAY : PH_CHK;
      end
      PH_PAY: begin
        result_d.payload_valid = 1'b1;
        result_d.payload_byte  = item_byte_i;
        result_d.payload_index = index_q;
        xor_d   = xor_q ^ item_byte_i;
        index_d = index_inc;
        if (index_inc >= length_q) begin
          phase_d = PH_CHK;
        end
      end
      PH_CHK: begin
        result_d.frame_done = 1'b1;
        result_d.frame_ok   = (item_byte_i == xor_q);
        phase_d             = PH_WAIT;
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase
    result_d.function_code  = function_d;
    result_d.payload_length = length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      function_q  <= '0;
      length_q    <= '0;
      index_q     <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_take_o) begin
        phase_q    <= phase_d;
        function_q <= function_d;
        length_q   <= length_d;
        index_q    <= index_d;
        xor_q      <= xor_d;
      end
      if (out_free) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // A result never carries both a payload byte and the end of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(result_q.payload_valid && result_q.frame_done))
    else $error("payload and frame end in one result");

  // A good checksum can only be reported on the checksum byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.frame_ok) |-> result_q.frame_done)
    else $error("frame_ok without frame_done");

  // Every payload byte lies inside the declared length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.payload_valid)
      |-> (result_q.payload_index < result_q.payload_length))
    else $error("payload index beyond declared length");

  // The checksum phase always hands back to waiting for a start byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_take_o && phase_q == PH_CHK) |=> (phase_q == PH_WAIT))
    else $error("checksum phase did not return to wait");

endmodule

// ===== design/frame_deframer_xor_checksum.sv =====
// Top level of the byte-serial frame deframer with XOR checksum.
`timescale 1ns / 1ps

// Accepts one received byte per clock while out_stall_i is low and returns one result per byte.
// Each byte passes through an input register, then the phase logic into a result register.
// Sustained rate is one byte per cycle while the output is not stalled. in_stall_o follows
// out_stall_i combinationally when both registers hold data. The start byte register may be
// written only while no byte is in flight.
module frame_deframer_xor_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic        frame_done_o,
  output logic        frame_ok_o,
  output logic [15:0] function_code_o,
  output logic [15:0] payload_length_o
);

  logic [7:0]           start_q;
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 take;
  logic                 in_free;
  fdx_pkg::fdx_result_t result;

  assign in_free      = !in_valid_q || take;
  assign in_stall_o   = !in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= fdx_pkg::START_BYTE_RESET;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (in_free) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  fdx_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_byte_i  (in_byte_q),
    .start_byte_i (start_q),
    .out_stall_i  (out_stall_i),
    .item_take_o  (take),
    .out_valid_o  (out_valid_o),
    .result_o     (result)
  );

  assign payload_valid_o  = result.payload_valid;
  assign payload_byte_o   = result.payload_byte;
  assign payload_index_o  = result.payload_index;
  assign frame_done_o     = result.frame_done;
  assign frame_ok_o       = result.frame_ok;
  assign function_code_o  = result.function_code;
  assign payload_length_o = result.payload_length;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the frame deframer with XOR checksum.
`timescale 1ns / 1ps

module tb;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_FUNC_HI,
    PH_FUNC_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CSUM
  } deframe_phase_e;

  localparam int LATENCY = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic        frame_done_o;
  logic        frame_ok_o;
  logic [15:0] function_code_o;
  logic [15:0] payload_length_o;

  frame_deframer_xor_checksum dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .frame_done_o     (frame_done_o),
    .frame_ok_o       (frame_ok_o),
    .function_code_o  (function_code_o),
    .payload_length_o (payload_length_o)
  );

  // Decoder state as the testbench sees it.
  logic [7:0]     start_model;
  deframe_phase_e phase_model;
  logic [15:0]    func_model;
  logic [15:0]    len_model;
  logic [15:0]    index_model;
  logic [7:0]     xor_model;

  fdx_pkg::fdx_result_t pending_decodes[$];
  int mismatches;
  int items_sent;
  int frames_good;
  int frames_bad;
  int payload_bytes;
  int tx_max_gap;
  int rx_max_gap;
  int rx_wait;
  int rx_hold;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic fdx_pkg::fdx_result_t decode_byte(logic [7:0] b);
    fdx_pkg::fdx_result_t r;
    r = '0;
    case (phase_model)
      PH_WAIT: begin
        if (b == start_model) begin
          func_model  = '0;
          len_model   = '0;
          index_model = '0;
          xor_model   = b;
          phase_model = PH_FUNC_HI;
        end
      end
      PH_FUNC_HI: begin
        func_model  = {b, 8'h00};
        xor_model   ^= b;
        phase_model = PH_FUNC_LO;
      end
      PH_FUNC_LO: begin
        func_model[7:0] = b;
        xor_model       ^= b;
        phase_model     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_model   = {b, 8'h00};
        xor_model   ^= b;
        phase_model = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_model[7:0] = b;
        xor_model      ^= b;
        if (len_model != 16'h0000) phase_model = PH_DATA;
        else phase_model = PH_CSUM;
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = index_model;
        xor_model       ^= b;
        index_model     = index_model + 16'd1;
        if (index_model >= len_model) phase_model = PH_CSUM;
      end
      PH_CSUM: begin
        r.frame_done = 1'b1;
        r.frame_ok   = (b == xor_model);
        phase_model  = PH_WAIT;
      end
      default: phase_model = PH_WAIT;
    endcase
    r.function_code  = func_model;
    r.payload_length = len_model;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("Mismatch on %s at %0t ns: got 0x%0h, wanted 0x%0h", field, $time, got, want);
    end
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_byte(logic [7:0] b);
    int                   gap;
    fdx_pkg::fdx_result_t want;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    want = decode_byte(b);
    pending_decodes.push_back(want);
    items_sent++;
    if (want.payload_valid) payload_bytes++;
    if (want.frame_done && want.frame_ok) frames_good++;
    if (want.frame_done && !want.frame_ok) frames_bad++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(logic [15:0] func, logic [15:0] len, bit bad_csum);
    logic [7:0] csum;
    logic [7:0] b;
    csum = start_model;
    send_byte(start_model);
    send_byte(func[15:8]);
    send_byte(func[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    csum ^= func[15:8] ^ func[7:0] ^ len[15:8] ^ len[7:0];
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 7) == 0) ? start_model : 8'($urandom_range(0, 255));
      csum ^= b;
      send_byte(b);
    end
    if (bad_csum) csum ^= 8'($urandom_range(1, 255));
    send_byte(csum);
  endtask

  task automatic send_noise(int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == start_model);
      send_byte(b);
    end
  endtask

  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_start_byte(logic [7:0] value);
    drain_decoder();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    start_model = value;
  endtask

  task automatic test_directed_frames();
    tx_max_gap = 4;
    rx_max_gap = 4;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_frame(16'hFFFF, 16'd0, 1'b0);
    send_frame(16'h0000, 16'd2, 1'b1);
    send_frame(16'hFEFE, 16'd1, 1'b0);
  endtask

  // The start byte changes while a frame is half received.
  task automatic test_start_byte_change_mid_frame();
    logic [7:0] csum;
    write_start_byte(8'hFE);
    csum = 8'hFE ^ 8'h12 ^ 8'h34 ^ 8'h00 ^ 8'h02 ^ 8'h00 ^ 8'hFE;
    send_byte(8'hFE);
    send_byte(8'h12);
    send_byte(8'h34);
    write_start_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(csum);
    send_byte(8'hFE);
    send_frame(16'h00A5, 16'd0, 1'b0);
    write_start_byte(8'hFF);
    send_frame(16'h8001, 16'd1, 1'b0);
  endtask

  task automatic test_long_frame();
    write_start_byte(8'hFE);
    tx_max_gap = 1;
    rx_max_gap = 1;
    send_frame(16'h5AA5, 16'h0103, 1'b0);
  endtask

  task automatic test_receiver_hold_off();
    drain_decoder();
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold    = 60;
    for (int i = 0; i < 4; i++) send_frame(16'($urandom_range(0, 65535)), 16'd6, 1'b0);
  endtask

  task automatic test_random_frames();
    int         kind;
    int         target;
    logic [7:0] start_values[4];
    start_values = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'hFE};
    for (int chunk = 0; chunk < 4; chunk++) begin
      write_start_byte(start_values[chunk]);
      tx_max_gap = (chunk % 2 == 0) ? 4 : 0;
      rx_max_gap = (chunk < 2) ? tx_max_gap : 4 - tx_max_gap;
      target = items_sent + 390;
      while (items_sent < target) begin
        kind = $urandom_range(0, 99);
        if (kind < 82) begin
          send_frame(16'($urandom_range(0, 65535)),
                     16'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                     : $urandom_range(0, 6)),
                     kind >= 70);
        end else if (kind < 92) begin
          send_noise($urandom_range(1, 4));
        end else begin
          send_frame(16'($urandom_range(0, 65535)), 16'd0, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold = rx_hold - 1;
    end else if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    fdx_pkg::fdx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_decodes.pop_front();
        if (payload_valid_o !== want.payload_valid)
          report_mismatch("payload_valid", payload_valid_o, want.payload_valid);
        if (payload_byte_o !== want.payload_byte)
          report_mismatch("payload_byte", payload_byte_o, want.payload_byte);
        if (payload_index_o !== want.payload_index)
          report_mismatch("payload_index", payload_index_o, want.payload_index);
        if (frame_done_o !== want.frame_done)
          report_mismatch("frame_done", frame_done_o, want.frame_done);
        if (frame_ok_o !== want.frame_ok)
          report_mismatch("frame_ok", frame_ok_o, want.frame_ok);
        if (function_code_o !== want.function_code)
          report_mismatch("function_code", function_code_o, want.function_code);
        if (payload_length_o !== want.payload_length)
          report_mismatch("payload_length", payload_length_o, want.payload_length);
      end
      rx_wait = $urandom_range(0, rx_max_gap);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'h00;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_stall_i = 1'b0;
    rx_wait     = 0;
    rx_hold     = 0;
    tx_max_gap  = 4;
    rx_max_gap  = 4;
    mismatches  = 0;
    items_sent  = 0;
    frames_good = 0;
    frames_bad  = 0;
    payload_bytes = 0;
    start_model = fdx_pkg::START_BYTE_RESET;
    phase_model = PH_WAIT;
    func_model  = '0;
    len_model   = '0;
    index_model = '0;
    xor_model   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_frames();
    test_start_byte_change_mid_frame();
    test_long_frame();
    test_receiver_hold_off();
    test_random_frames();

    drain_decoder();
    repeat (LATENCY * 4) @(negedge clk_i);
    if (pending_decodes.size() != 0)
      report_mismatch("results never received", pending_decodes.size(), 0);
    $display("Covered %0d bytes: %0d frames closed (%0d good, %0d bad checksum), ",
             items_sent, frames_good + frames_bad, frames_good, frames_bad,
             "%0d payload bytes.", payload_bytes);
    $display("Start bytes 0x00, 0xFF, 0xFE and one random value, a mid-frame change, ",
             "a 259-byte payload and a long output hold-off were exercised.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
